// ===== design/nbbs_pkg.sv =====
// Shared constants, codes and saturating position helpers for the noisy
// bisection boundary search. Used by the top level; no dependencies.
`default_nettype none

package nbbs_pkg;

	localparam int POS_W = 32;
	localparam int WGT_W = 32;
	localparam int TABLE_DEPTH_DEF = 256;

	localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

	// Weights are unsigned Q2.30.
	localparam logic [WGT_W-1:0] W_ONE  = 32'h4000_0000;
	localparam logic [WGT_W-1:0] W_HALF = 32'h2000_0000;
	localparam logic [WGT_W-1:0] W_TWO  = 32'h8000_0000;
	localparam logic [WGT_W-1:0] W_THREE = 32'hC000_0000;

	// Quotient bits the divider produces for one reweighted entry.
	localparam logic [5:0] DIV_STEPS = 6'd33;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_VERDICT = 1'b1;

	localparam logic [1:0] VD_STABLE   = 2'd0;
	localparam logic [1:0] VD_UNSTABLE = 2'd1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;
	localparam logic [1:0] ST_IDLE = 2'd3;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_START = 2'd1;
	localparam logic [1:0] REG_STEP  = 2'd2;
	localparam logic [1:0] REG_TOL   = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] value;
		logic                    sat;
	} pos_res_t;

	function automatic pos_res_t pos_add_sat(logic signed [POS_W-1:0] a,
		logic [POS_W-2:0] b);
		logic signed [POS_W:0] sum;
		pos_res_t r;
		sum = {a[POS_W-1], a} + $signed({2'b00, b});
		r.sat = sum[POS_W] ^ sum[POS_W-1];
		r.value = r.sat ? POS_MAX : sum[POS_W-1:0];
		return r;
	endfunction

	function automatic pos_res_t pos_sub_sat(logic signed [POS_W-1:0] a,
		logic [POS_W-2:0] b);
		logic signed [POS_W:0] dif;
		pos_res_t r;
		dif = {a[POS_W-1], a} - $signed({2'b00, b});
		r.sat = dif[POS_W] ^ dif[POS_W-1];
		r.value = r.sat ? POS_MIN : dif[POS_W-1:0];
		return r;
	endfunction

	// Width of b - a for signed a, b, taken as zero when b is below a.
	function automatic logic [POS_W-1:0] gap_of(logic signed [POS_W-1:0] a,
		logic signed [POS_W-1:0] b);
		logic signed [POS_W:0] dif;
		dif = {b[POS_W-1], b} - {a[POS_W-1], a};
		return dif[POS_W] ? '0 : dif[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/nbbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nbbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/noisy_bisection_boundary_search.sv =====
// Noisy bisection boundary search top level; uses nbbs_pkg and the nbbs_ram table.
// Start beats, ignored verdicts and bracketing beats that leave the bracket open answer
// in the cycle after acceptance. Closing the bracket seeds the table; it and a refining
// verdict (rescaling every entry in the shared 33-step divider first) run a split scan and
// insertion sweep or the median scan. One beat at a time; the result cannot be stalled.
// The async reset clears control state and registers; the point table needs no clearing.
`default_nettype none

module noisy_bisection_boundary_search #(
	parameter int TABLE_DEPTH = nbbs_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               command,
	input  wire logic [1:0]         verdict,
	output logic                    valid,
	output logic signed [31:0]      position,
	output logic                    is_final,
	output logic [1:0]              status,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CNTW = AW + 1;
	localparam int CUMW = nbbs_pkg::WGT_W + AW + 1;
	localparam int PW   = nbbs_pkg::POS_W;
	localparam int WW   = nbbs_pkg::WGT_W;

	typedef enum logic [1:0] {PH_IDLE, PH_UPPER, PH_LOWER, PH_REFINE} phase_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_CONT,
		S_SC_RD, S_SC_LD, S_SC_DIV, S_SC_WR,
		S_MD_RD, S_MD_CHK,
		S_SP_RD, S_SP_CHK, S_SP_RDB, S_SP_B,
		S_SH_RD, S_SH_WR, S_SP_W1, S_SP_W0
	} state_t;

	// Configuration registers.
	logic                 mode_q;
	logic signed [PW-1:0] start_pos_q;
	logic [PW-2:0]        start_step_q;
	logic [PW-2:0]        tol_q;

	// Search state.
	state_t               state_q;
	phase_t               phase_q;
	logic signed [PW-1:0] probe_q;
	logic [PW-2:0]        step_q;
	logic signed [PW-1:0] upper_q;
	logic signed [PW-1:0] lower_q;
	logic signed [PW-1:0] pos2_q;
	logic [CNTW-1:0]      count_q;
	logic [WW-2:0]        bm_q;
	logic [PW-1:0]        gap_q;
	logic                 sat_q;
	logic [1:0]           fin_status_q;

	// Sequencer working registers.
	logic [AW-1:0]        idx_q;
	logic [AW-1:0]        jdx_q;
	logic [CUMW-1:0]      cum_q;
	logic                 too_low_q;
	logic [WW-1:0]        den_q;
	logic signed [PW-1:0] ent_pos_q;
	logic signed [PW-1:0] apos_q;
	logic [WW-1:0]        whalf_q;
	logic [31:0]          rem_q;
	logic [32:0]          num_q;
	logic [33:0]          quo_q;
	logic [5:0]           bit_cnt_q;

	// Result registers.
	logic                 valid_q;
	logic signed [31:0]   position_q;
	logic                 is_final_q;
	logic [1:0]           status_q;

	// Point table: position in the upper half, weight in the lower half.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [PW+WW-1:0]     ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [PW+WW-1:0]     ram_rdata;
	logic signed [PW-1:0] rd_pos;
	logic [WW-1:0]        rd_w;

	nbbs_ram #(
		.WIDTH(PW + WW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_pos = ram_rdata[PW+WW-1:WW];
	assign rd_w   = ram_rdata[WW-1:0];

	logic accept;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// APB port. Every write completes in its access cycle.
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			nbbs_pkg::REG_MODE:  prdata = {31'b0, mode_q};
			nbbs_pkg::REG_START: prdata = start_pos_q;
			nbbs_pkg::REG_STEP:  prdata = {1'b0, start_step_q};
			nbbs_pkg::REG_TOL:   prdata = {1'b0, tol_q};
			default:             prdata = '0;
		endcase
	end

	// Bracketing arithmetic, used only in the cycle a beat is accepted.
	nbbs_pkg::pos_res_t padd, psub, up2;
	logic [PW-2:0]        step_dbl;
	logic                 hit;
	logic                 too_low;
	assign padd = nbbs_pkg::pos_add_sat(probe_q, step_q);
	assign psub = nbbs_pkg::pos_sub_sat(probe_q, step_q);
	assign up2  = nbbs_pkg::pos_add_sat(upper_q, step_q);
	assign step_dbl = step_q[PW-2] ? {(PW-1){1'b1}} : {step_q[PW-3:0], 1'b0};
	assign hit = (phase_q == PH_UPPER) ? (verdict == nbbs_pkg::VD_STABLE)
		: (verdict == nbbs_pkg::VD_UNSTABLE);
	assign too_low = mode_q ? (verdict == nbbs_pkg::VD_UNSTABLE)
		: (verdict != nbbs_pkg::VD_STABLE);

	// Scan and divider datapath.
	logic [CUMW-1:0]      cum_n;
	logic [CUMW-1:0]      prob;
	logic                 below;
	logic                 k3;
	logic [33:0]          wk;
	logic [32:0]          r2;
	logic                 ge;
	logic [WW-1:0]        qsat;
	logic [1:0]           ok_status;
	logic signed [PW:0]   mid_sum;
	logic [AW-1:0]        last_idx;
	logic [AW-1:0]        split_last;
	logic [AW-1:0]        next_idx;

	assign cum_n   = cum_q + CUMW'(rd_w);
	assign prob    = cum_n - CUMW'(rd_w >> 1);
	assign below   = rd_pos < probe_q;
	assign k3      = too_low_q ? !below : below;
	assign wk      = k3 ? ({1'b0, rd_w, 1'b0} + {2'b00, rd_w}) : {1'b0, rd_w, 1'b0};
	assign r2      = {rem_q, num_q[32]};
	assign ge      = r2 >= {1'b0, den_q};
	assign qsat    = (|quo_q[33:32]) ? {WW{1'b1}} : quo_q[31:0];
	assign ok_status = sat_q ? nbbs_pkg::ST_SAT : nbbs_pkg::ST_OK;
	assign mid_sum = {apos_q[PW-1], apos_q} + {rd_pos[PW-1], rd_pos};
	assign last_idx   = AW'(count_q - CNTW'(1));
	assign split_last = AW'(count_q - CNTW'(2));
	assign next_idx   = AW'(idx_q + AW'(1));

	// The median scan ends past half the mass or at the last entry.
	logic md_done;
	assign md_done = (cum_n > CUMW'(nbbs_pkg::W_HALF)) || (idx_q == last_idx);

	// A result beat leaves on every accepted beat that does not start a table pass,
	// at the end of the final median scan, and after a split is written back.
	logic emit_now;
	assign emit_now = (accept && (command == nbbs_pkg::CMD_START || phase_q == PH_IDLE
		|| phase_q == PH_UPPER || (phase_q == PH_LOWER && !hit)))
		|| (state_q == S_MD_CHK && md_done) || (state_q == S_SP_W0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_q;
		case (state_q)
			S_INIT0: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(0);
				ram_wdata = {lower_q, nbbs_pkg::W_HALF};
			end
			S_INIT1: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(1);
				ram_wdata = {upper_q, nbbs_pkg::W_HALF};
			end
			S_INIT2: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(2);
				ram_wdata = {pos2_q, {WW{1'b0}}};
			end
			S_SC_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {ent_pos_q, qsat};
			end
			S_SP_RDB: ram_raddr = next_idx;
			S_SH_RD:  ram_raddr = jdx_q;
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(jdx_q + AW'(1));
				ram_wdata = ram_rdata;
			end
			S_SP_W1: begin
				ram_we    = 1'b1;
				ram_waddr = next_idx;
				ram_wdata = {probe_q, whalf_q};
			end
			S_SP_W0: begin
				ram_we    = 1'b1;
				ram_wdata = {apos_q, whalf_q};
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			start_pos_q  <= '0;
			start_step_q <= 31'd65536;
			tol_q        <= 31'd3;
			state_q      <= S_IDLE;
			phase_q      <= PH_IDLE;
			probe_q      <= '0;
			step_q       <= '0;
			upper_q      <= '0;
			lower_q      <= '0;
			pos2_q       <= '0;
			count_q      <= '0;
			bm_q         <= '0;
			gap_q        <= '0;
			sat_q        <= 1'b0;
			fin_status_q <= nbbs_pkg::ST_OK;
			idx_q        <= '0;
			jdx_q        <= '0;
			cum_q        <= '0;
			too_low_q    <= 1'b0;
			den_q        <= '0;
			ent_pos_q    <= '0;
			apos_q       <= '0;
			whalf_q      <= '0;
			rem_q        <= '0;
			num_q        <= '0;
			quo_q        <= '0;
			bit_cnt_q    <= '0;
			valid_q      <= 1'b0;
			position_q   <= '0;
			is_final_q   <= 1'b0;
			status_q     <= nbbs_pkg::ST_OK;
		end else begin
			valid_q <= emit_now;

			if (cfg_wr) begin
				unique case (paddr[3:2])
					nbbs_pkg::REG_MODE:  mode_q       <= pwdata[0];
					nbbs_pkg::REG_START: start_pos_q  <= pwdata;
					nbbs_pkg::REG_STEP:  start_step_q <= pwdata[30:0];
					nbbs_pkg::REG_TOL:   tol_q        <= pwdata[30:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == nbbs_pkg::CMD_START) begin
							step_q     <= (start_step_q == '0) ? (PW-1)'(1) : start_step_q;
							probe_q    <= start_pos_q;
							phase_q    <= PH_UPPER;
							position_q <= start_pos_q;
							is_final_q <= 1'b0;
							status_q   <= nbbs_pkg::ST_OK;
						end else if (phase_q == PH_IDLE) begin
							position_q <= probe_q;
							is_final_q <= 1'b0;
							status_q   <= nbbs_pkg::ST_IDLE;
						end else if (phase_q == PH_UPPER && hit) begin
							upper_q    <= padd.value;
							probe_q    <= psub.value;
							phase_q    <= PH_LOWER;
							position_q <= psub.value;
							is_final_q <= 1'b0;
							status_q   <= (padd.sat || psub.sat) ? nbbs_pkg::ST_SAT
								: nbbs_pkg::ST_OK;
						end else if (phase_q == PH_LOWER && hit) begin
							// Seed the table with the bracket and a zero-weight
							// guard point above it.
							lower_q <= psub.value;
							pos2_q  <= up2.value;
							gap_q   <= nbbs_pkg::gap_of(psub.value, upper_q);
							count_q <= CNTW'(3);
							sat_q   <= psub.sat || up2.sat;
							phase_q <= PH_REFINE;
							state_q <= S_INIT0;
						end else if (phase_q == PH_UPPER || phase_q == PH_LOWER) begin
							probe_q    <= (phase_q == PH_UPPER) ? padd.value : psub.value;
							step_q     <= step_dbl;
							position_q <= (phase_q == PH_UPPER) ? padd.value : psub.value;
							is_final_q <= 1'b0;
							status_q   <= ((phase_q == PH_UPPER) ? padd.sat : psub.sat)
								? nbbs_pkg::ST_SAT : nbbs_pkg::ST_OK;
						end else begin
							// Refining verdict: rescale every weight.
							sat_q     <= 1'b0;
							too_low_q <= too_low;
							den_q     <= too_low ? (nbbs_pkg::W_THREE - WW'(bm_q))
								: (nbbs_pkg::W_TWO + WW'(bm_q));
							idx_q     <= '0;
							state_q   <= S_SC_RD;
						end
					end
				end
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_INIT2;
				S_INIT2: state_q <= S_CONT;
				S_CONT: begin
					idx_q <= '0;
					cum_q <= '0;
					if (gap_q > {1'b0, tol_q}) begin
						if (count_q == CNTW'(TABLE_DEPTH)) begin
							fin_status_q <= nbbs_pkg::ST_FULL;
							state_q      <= S_MD_RD;
						end else begin
							state_q <= S_SP_RD;
						end
					end else begin
						fin_status_q <= nbbs_pkg::ST_OK;
						state_q      <= S_MD_RD;
					end
				end
				S_SC_RD: state_q <= S_SC_LD;
				S_SC_LD: begin
					ent_pos_q <= rd_pos;
					rem_q     <= 32'(wk[33:3]);
					num_q     <= {wk[2:0], 30'b0};
					quo_q     <= '0;
					bit_cnt_q <= nbbs_pkg::DIV_STEPS;
					state_q   <= S_SC_DIV;
				end
				S_SC_DIV: begin
					rem_q     <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
					quo_q     <= {quo_q[32:0], ge};
					num_q     <= {num_q[31:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - 6'd1;
					if (bit_cnt_q == 6'd1) begin
						state_q <= S_SC_WR;
					end
				end
				S_SC_WR: begin
					if (idx_q == last_idx) begin
						state_q <= S_CONT;
					end else begin
						idx_q   <= next_idx;
						state_q <= S_SC_RD;
					end
				end
				S_MD_RD: state_q <= S_MD_CHK;
				S_MD_CHK: begin
					if (md_done) begin
						position_q <= rd_pos;
						is_final_q <= 1'b1;
						status_q   <= (fin_status_q == nbbs_pkg::ST_OK) ? ok_status
							: fin_status_q;
						phase_q    <= PH_IDLE;
						state_q    <= S_IDLE;
					end else begin
						cum_q   <= cum_n;
						idx_q   <= next_idx;
						state_q <= S_MD_RD;
					end
				end
				S_SP_RD: state_q <= S_SP_CHK;
				S_SP_CHK: begin
					// Stop at the median interval, or at the last one that exists.
					if (cum_n >= CUMW'(nbbs_pkg::W_HALF) || idx_q == split_last) begin
						apos_q  <= rd_pos;
						whalf_q <= rd_w >> 1;
						bm_q    <= (prob > CUMW'(nbbs_pkg::W_ONE))
							? (WW-1)'(nbbs_pkg::W_ONE) : (WW-1)'(prob);
						state_q <= S_SP_RDB;
					end else begin
						cum_q   <= cum_n;
						idx_q   <= next_idx;
						state_q <= S_SP_RD;
					end
				end
				S_SP_RDB: state_q <= S_SP_B;
				S_SP_B: begin
					gap_q   <= nbbs_pkg::gap_of(apos_q, rd_pos);
					probe_q <= mid_sum[PW:1];
					jdx_q   <= last_idx;
					state_q <= S_SH_RD;
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					if (jdx_q == next_idx) begin
						state_q <= S_SP_W1;
					end else begin
						jdx_q   <= AW'(jdx_q - AW'(1));
						state_q <= S_SH_RD;
					end
				end
				S_SP_W1: state_q <= S_SP_W0;
				S_SP_W0: begin
					count_q    <= count_q + CNTW'(1);
					position_q <= probe_q;
					is_final_q <= 1'b0;
					status_q   <= ok_status;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign valid    = valid_q;
	assign position = position_q;
	assign is_final = is_final_q;
	assign status   = status_q;

	// An accepted beat either answers in the next cycle or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (valid || busy))
		else $error("accepted beat neither answered nor started work");

	// A final estimate always ends the search.
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && is_final) |-> (phase_q == PH_IDLE && !busy))
		else $error("final estimate while search still running");

	// An ignored verdict never reports a final estimate.
	a_idle_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status == nbbs_pkg::ST_IDLE) |-> !is_final)
		else $error("ignored verdict marked final");

	// The table never holds more points than it has rows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(TABLE_DEPTH))
		else $error("point count beyond table depth");

	// Results only leave the block when it has just gone idle or never left it.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy || (phase_q == PH_REFINE && $past(state_q) == S_IDLE))
		else $error("result strobe while sequencer is mid-pass");

endmodule

`default_nettype wire
